/* src/pspd_pkg.sv */
// ----------------------------------------------------------------------------
// pspd_pkg
// Shared widths, register codes and types of the wheel speed controller.
// ----------------------------------------------------------------------------
package pspd_pkg;

	localparam int GAIN_W  = 16;
	localparam int VAL_W   = 16;
	localparam int ERR_W   = 17;
	localparam int COEF_W  = 19;
	localparam int PROD_W  = 36;
	localparam int ACC_W   = 40;
	localparam int SUM_W   = 42;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [1:0] REG_GAIN_P    = 2'd0;
	localparam logic [1:0] REG_GAIN_I    = 2'd1;
	localparam logic [1:0] REG_GAIN_D    = 2'd2;
	localparam logic [1:0] REG_PWM_LIMIT = 2'd3;

	localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 16'd384;
	localparam logic [GAIN_W-1:0] GAIN_I_RESET    = 16'd128;
	localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 16'd0;
	localparam logic [GAIN_W-1:0] PWM_LIMIT_RESET = 16'd4199;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [GAIN_W-1:0] pwm_limit;
	} pspd_cfg_t;

	// One wheel's controller state as held in the state memory.
	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [ERR_W-1:0] err_last;
		logic signed [ERR_W-1:0] err_prev;
	} pspd_state_t;

endpackage

/* src/pspd_req_if.sv */
// ----------------------------------------------------------------------------
// pspd_req_if
// Request channel: one control tick or direct drive per transfer.
// ----------------------------------------------------------------------------
interface pspd_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic               wheel;
	logic signed [15:0] encoder_count;
	logic signed [15:0] speed_setpoint;
	logic signed [15:0] drive_value;

	modport source (
		output valid, cmd, wheel, encoder_count, speed_setpoint, drive_value,
		input  ready
	);
	modport sink (
		input  valid, cmd, wheel, encoder_count, speed_setpoint, drive_value,
		output ready
	);
endinterface

/* src/pspd_rsp_if.sv */
// ----------------------------------------------------------------------------
// pspd_rsp_if
// Result channel: duty and direction for one wheel per transfer.
// ----------------------------------------------------------------------------
interface pspd_rsp_if;
	logic        valid;
	logic        ready;
	logic        wheel_out;
	logic [15:0] duty;
	logic        dir_forward;

	modport source (
		output valid, wheel_out, duty, dir_forward,
		input  ready
	);
	modport sink (
		input  valid, wheel_out, duty, dir_forward,
		output ready
	);
endinterface

/* src/pspd_apb_regs.sv */
// ----------------------------------------------------------------------------
// pspd_apb_regs
// APB register file holding the three gains and the PWM limit.
// ----------------------------------------------------------------------------
module pspd_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pspd_pkg::ADDR_W-1:0]  paddr,
	input  logic [pspd_pkg::DATA_W-1:0]  pwdata,
	output logic [pspd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pspd_pkg::pspd_cfg_t          cfg
);
	import pspd_pkg::*;

	logic       wr_en;
	logic [1:0] reg_sel;
	pspd_cfg_t  cfg_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= GAIN_P_RESET;
			cfg_q.gain_i    <= GAIN_I_RESET;
			cfg_q.gain_d    <= GAIN_D_RESET;
			cfg_q.pwm_limit <= PWM_LIMIT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_GAIN_P:    cfg_q.gain_p    <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d    <= pwdata[GAIN_W-1:0];
				REG_PWM_LIMIT: cfg_q.pwm_limit <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAIN_P:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.gain_p};
			REG_GAIN_I:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.gain_i};
			REG_GAIN_D:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.gain_d};
			REG_PWM_LIMIT: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.pwm_limit};
			default:       prdata = '0;
		endcase
	end

endmodule

/* src/pid_speed_to_pwm_direction_unit.sv */
// ----------------------------------------------------------------------------
// pid_speed_to_pwm_direction_unit
// Incremental PID speed controller per wheel with PWM duty and direction out.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the result channel is free and
// returns one result for each, in order, from an output register. Each wheel's
// accumulator and last two errors live in one state memory
// with a registered read; the read issued at the request transfer, forwarding
// from the two stages ahead of it and the write-back at the end of the add stage
// together set the one-item-per-cycle rate, even for the same wheel back to
// back. The state reads as zero after reset through per-entry valid bits, so
// no clearing pass is needed. A direct drive request bypasses the PID and
// leaves the state untouched. Gains are unsigned with GAIN_FRAC_BITS fraction
// bits; the duty is the clamped magnitude truncated toward zero.
module pid_speed_to_pwm_direction_unit #(
	parameter int WHEELS         = 2,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pspd_pkg::ADDR_W-1:0]  paddr,
	input  logic [pspd_pkg::DATA_W-1:0]  pwdata,
	output logic [pspd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	pspd_req_if.sink                     req,
	pspd_rsp_if.source                   rsp
);
	import pspd_pkg::*;

	localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int LIM_W = GAIN_W + GAIN_FRAC_BITS;
	localparam int CMP_W = ACC_W + 1;

	pspd_cfg_t cfg;

	pspd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline control.
	logic adv;
	logic accept;
	logic out_load;
	logic out_valid_q;
	logic v_s1, v_s2, v_s3;

	// State memory and its valid bits.
	pspd_state_t       mem [WHEELS];
	pspd_state_t       rd_s1;
	logic              rd_vld_s1;
	logic [WHEELS-1:0] vld_q;
	logic              mem_we;
	pspd_state_t       wr_entry;

	// Stage payloads.
	logic [IDX_W-1:0]        idx_in;
	logic signed [ERR_W-1:0] err_in;
	logic                    tick_s1, tick_s2, tick_s3;
	logic                    wheel_s1, wheel_s2, wheel_s3;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic signed [ERR_W-1:0] e_s1, e_s2, e_s3;
	logic signed [ERR_W-1:0] e1_s2, e1_s3;
	logic signed [VAL_W-1:0] drv_s1;
	logic signed [ACC_W-1:0] drv_q_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [ACC_W-1:0] q_s3;

	// Coefficients and stage-1 forwarding.
	logic [COEF_W-2:0]        a0_mag, a1_mag;
	logic signed [COEF_W-1:0] c0, c1, c2;
	pspd_state_t              base_s1;
	logic                     hit2_s1, hit3_s1, hit3_s2;
	logic signed [ERR_W-1:0]  e1_fwd, e2_fwd;
	logic signed [ACC_W-1:0]  acc_fwd;

	// Stage-2 sum and stage-3 clamp.
	logic signed [ACC_W-1:0] acc_in_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic signed [ACC_W-1:0] sat_s2;
	logic signed [ACC_W-1:0] q_next_s2;
	logic signed [CMP_W-1:0] lim_c, q_c, qc_c, mag_c;
	logic [LIM_W-1:0]        lim_u;

	logic        out_wheel_q;
	logic [15:0] out_duty_q;
	logic        out_fwd_q;

	assign out_load  = v_s3 && (!out_valid_q || rsp.ready);
	assign adv       = !v_s3 || out_load;
	assign req.ready = adv;
	assign accept    = req.valid && adv;

	assign idx_in = (WHEELS > 1) ? IDX_W'(req.wheel) : '0;
	assign err_in = $signed({req.speed_setpoint[15], req.speed_setpoint})
	              - $signed({req.encoder_count[15], req.encoder_count});

	// Incremental form: A0 = Kp+Ki+Kd, A1 = -(Kp+2Kd), A2 = Kd.
	assign a0_mag = (COEF_W-1)'(cfg.gain_p) + (COEF_W-1)'(cfg.gain_i)
	              + (COEF_W-1)'(cfg.gain_d);
	assign a1_mag = (COEF_W-1)'(cfg.gain_p) + ((COEF_W-1)'(cfg.gain_d) << 1);
	assign c0     = $signed({1'b0, a0_mag});
	assign c1     = -$signed({1'b0, a1_mag});
	assign c2     = $signed({{(COEF_W-GAIN_W){1'b0}}, cfg.gain_d});

	// The two items ahead may hold newer state than the memory read returned.
	always_comb begin
		base_s1 = rd_vld_s1 ? rd_s1 : '0;
		hit2_s1 = v_s2 && tick_s2 && (idx_s2 == idx_s1);
		hit3_s1 = v_s3 && tick_s3 && (idx_s3 == idx_s1);
		if (hit2_s1) begin
			e1_fwd = e_s2;
			e2_fwd = e1_s2;
		end else if (hit3_s1) begin
			e1_fwd = e_s3;
			e2_fwd = e1_s3;
		end else begin
			e1_fwd = base_s1.err_last;
			e2_fwd = base_s1.err_prev;
		end
		acc_fwd = hit3_s1 ? q_s3 : base_s1.acc;
	end

	// The item directly ahead finishes its accumulator only now; take it here.
	always_comb begin
		hit3_s2   = v_s3 && tick_s3 && (idx_s3 == idx_s2);
		acc_in_s2 = hit3_s2 ? q_s3 : acc_s2;
		sum_s2    = SUM_W'(acc_in_s2) + SUM_W'(p0_s2) + SUM_W'(p1_s2) + SUM_W'(p2_s2);
		if (sum_s2[SUM_W-1:ACC_W-1] != '0 && sum_s2[SUM_W-1:ACC_W-1] != '1) begin
			sat_s2 = sum_s2[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
			                         : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_s2 = sum_s2[ACC_W-1:0];
		end
		q_next_s2 = tick_s2 ? sat_s2 : drv_q_s2;
	end

	assign mem_we            = adv && v_s2 && tick_s2;
	assign wr_entry.acc      = sat_s2;
	assign wr_entry.err_last = e_s2;
	assign wr_entry.err_prev = e1_s2;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_s2] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[idx_in];
		end
	end

	// Clamp to plus or minus the limit; direction follows the clamped sign.
	always_comb begin
		lim_u = {cfg.pwm_limit, {GAIN_FRAC_BITS{1'b0}}};
		lim_c = $signed({{(CMP_W-LIM_W){1'b0}}, lim_u});
		q_c   = $signed({q_s3[ACC_W-1], q_s3});
		if (q_c > lim_c) begin
			qc_c = lim_c;
		end else if (q_c < -lim_c) begin
			qc_c = -lim_c;
		end else begin
			qc_c = q_c;
		end
		mag_c = qc_c[CMP_W-1] ? -qc_c : qc_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (adv) begin
				v_s1      <= accept;
				v_s2      <= v_s1;
				v_s3      <= v_s2;
				rd_vld_s1 <= vld_q[idx_in];
			end
			if (mem_we) begin
				vld_q[idx_s2] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1  <= !req.cmd;
			wheel_s1 <= req.wheel;
			idx_s1   <= idx_in;
			e_s1     <= err_in;
			drv_s1   <= req.drive_value;

			tick_s2  <= tick_s1;
			wheel_s2 <= wheel_s1;
			idx_s2   <= idx_s1;
			e_s2     <= e_s1;
			e1_s2    <= e1_fwd;
			acc_s2   <= acc_fwd;
			p0_s2    <= c0 * e_s1;
			p1_s2    <= c1 * e1_fwd;
			p2_s2    <= c2 * e2_fwd;
			drv_q_s2 <= {{(ACC_W-VAL_W-GAIN_FRAC_BITS){drv_s1[VAL_W-1]}}, drv_s1,
			             {GAIN_FRAC_BITS{1'b0}}};

			tick_s3  <= tick_s2;
			wheel_s3 <= wheel_s2;
			idx_s3   <= idx_s2;
			e_s3     <= e_s2;
			e1_s3    <= e1_s2;
			q_s3     <= q_next_s2;
		end
		if (out_load) begin
			out_wheel_q <= wheel_s3;
			out_duty_q  <= mag_c[GAIN_FRAC_BITS +: 16];
			out_fwd_q   <= !qc_c[CMP_W-1];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.wheel_out   = out_wheel_q;
	assign rsp.duty        = out_duty_q;
	assign rsp.dir_forward = out_fwd_q;

`ifndef NO_ASSERTIONS
	// A result stuck at the output with a full last stage must hold off requests.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready && v_s3) |-> !req.ready)
		else $error("request taken while the pipeline is blocked");

	// Every accepted request enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> v_s1)
		else $error("accepted request lost before stage one");

	// A written wheel entry is marked valid afterwards.
	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> vld_q[$past(idx_s2)])
		else $error("state entry written but not marked valid");

	// Moving the last stage out always presents a result.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp.valid)
		else $error("result moved out but not presented");
`endif

endmodule
